// File: hdl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants of the inflection point detector
// Point and result payload types, the command that travels through the
// queue from the front end to the back end, the queue status and the
// sign codes of slopes and slope differences.
// ----------------------------------------------------------------------------
package ipd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int INDEX_WIDTH = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2,
        SIGN_BAD  = 2'd3
    } sign_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic                          series_start;
    } ipd_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] found_x;
        logic signed [COORD_WIDTH-1:0] found_y;
        logic [INDEX_WIDTH-1:0]        found_index;
    } ipd_out_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic                          first;
        logic signed [COORD_WIDTH:0]   delta_x;
        logic signed [COORD_WIDTH:0]   delta_y;
    } ipd_cmd_t;

    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic [QUEUE_CNT_W-1:0] level;
    } ipd_qstat_t;

endpackage

// File: hdl/inflection_point_detector_top.sv
// ----------------------------------------------------------------------------
// inflection_point_detector_top: inflection point detector
// Finds points where the second difference of a Q16.16 point series
// changes sign between slopes of one nonzero sign, and reports them.
//
// Channel   Direction  Ports                      Payload
// s_        in         s_valid, s_ready, s_data   ipd_in_t: point_x, point_y, series_start
// m_        out        m_valid, m_ready, m_data   ipd_out_t: found_x, found_y, found_index
//
// A point that starts a series is taken in the idle state and not divided.
// A point with zero dx goes from idle straight to the evaluation step; any
// other point passes through the restoring divider, which produces one
// quotient bit per cycle, then through the slope step and the evaluation step.
// A two-entry queue lets the front end accept points while the back end
// divides. Reset is synchronous and empties queue, history and output.
// While a result waits in the output register, the back end holds in its
// final step and the queue fills.
// ----------------------------------------------------------------------------
module inflection_point_detector_top import ipd_pkg::*; #(
    parameter int FRAC_BITS   = 16,
    parameter int SLOPE_WIDTH = 48
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ipd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ipd_out_t m_data
);

    ipd_qstat_t q_stat;
    ipd_cmd_t   q_cmd;
    ipd_cmd_t   q_head;
    logic       q_push;
    logic       q_pop;

    ipd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .push    (q_push),
        .cmd     (q_cmd)
    );

    ipd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .cmd     (q_cmd),
        .pop     (q_pop),
        .head    (q_head),
        .q_stat  (q_stat)
    );

    ipd_back #(
        .FRAC_BITS   (FRAC_BITS),
        .SLOPE_WIDTH (SLOPE_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .head    (q_head),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_pop_nonempty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty
    ) else $error("Back end popped an empty queue.");

    a_level_bound: assert property (
        @(posedge aclk) disable iff (!aresetn)
        q_stat.level <= QUEUE_CNT_W'(QUEUE_DEPTH)
    ) else $error("Queue level exceeds its depth.");

    a_reset_clear: assert property (
        @(posedge aclk)
        !aresetn |=> (!m_valid && s_ready && q_stat.empty)
    ) else $error("Reset did not clear the output and the queue.");

endmodule

// File: hdl/ipd_front.sv
// ----------------------------------------------------------------------------
// ipd_front: input stage of the inflection point detector
// Accepts points, keeps the previous point and forms the coordinate
// differences, and marks the first point of each series.
// ----------------------------------------------------------------------------
module ipd_front import ipd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ipd_in_t    s_data,
    input  ipd_qstat_t q_stat,
    output logic       push,
    output ipd_cmd_t   cmd
);

    logic                   have_reg;
    logic [COORD_WIDTH-1:0] prev_x_reg;
    logic [COORD_WIDTH-1:0] prev_y_reg;

    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    assign cmd.point_x = s_data.point_x;
    assign cmd.point_y = s_data.point_y;
    assign cmd.first   = s_data.series_start || !have_reg;
    assign cmd.delta_x = {s_data.point_x[COORD_WIDTH-1], s_data.point_x}
                       - {prev_x_reg[COORD_WIDTH-1], prev_x_reg};
    assign cmd.delta_y = {s_data.point_y[COORD_WIDTH-1], s_data.point_y}
                       - {prev_y_reg[COORD_WIDTH-1], prev_y_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (push) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            prev_x_reg <= s_data.point_x;
            prev_y_reg <= s_data.point_y;
        end
    end

endmodule

// File: hdl/ipd_queue.sv
// ----------------------------------------------------------------------------
// ipd_queue: command queue between front end and back end
// A small first-in first-out buffer with show-ahead read.
// ----------------------------------------------------------------------------
module ipd_queue import ipd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  ipd_cmd_t   cmd,
    input  logic       pop,
    output ipd_cmd_t   head,
    output ipd_qstat_t q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    ipd_cmd_t               mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] level_reg;
    logic [QUEUE_CNT_W-1:0] level_next;
    logic                   do_push;
    logic                   do_pop;

    assign q_stat.full  = (level_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (level_reg == '0);
    assign q_stat.level = level_reg;
    assign head         = mem_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb begin
        level_next = level_reg;
        if (do_push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// File: hdl/ipd_back.sv
// ----------------------------------------------------------------------------
// ipd_back: slope divider and inflection test of the detector
// Divides dy by dx one quotient bit per cycle, saturates the slope, tracks
// the sign of the second difference and loads the result register.
// ----------------------------------------------------------------------------
module ipd_back import ipd_pkg::*; #(
    parameter int FRAC_BITS   = 16,
    parameter int SLOPE_WIDTH = 48
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ipd_qstat_t q_stat,
    input  ipd_cmd_t   head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output ipd_out_t   m_data
);

    localparam int NUM_W  = COORD_WIDTH + FRAC_BITS;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int CMP_W  = ((NUM_W > SLOPE_WIDTH) ? NUM_W : SLOPE_WIDTH) + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_SLOPE = 4'b0100,
        ST_EVAL  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [COORD_WIDTH-1:0]        cur_x_reg;
    logic [COORD_WIDTH-1:0]        cur_y_reg;
    logic [COORD_WIDTH-1:0]        older_x_reg;
    logic [COORD_WIDTH-1:0]        older_y_reg;
    logic [COORD_WIDTH-1:0]        newer_x_reg;
    logic [COORD_WIDTH-1:0]        newer_y_reg;
    logic                          neg_reg;
    logic [COORD_WIDTH-1:0]        adx_reg;
    logic [COORD_WIDTH-1:0]        rem_reg;
    logic [NUM_W-1:0]              num_reg;
    logic [STEP_W-1:0]             step_reg;
    logic signed [SLOPE_WIDTH-1:0] f_reg;
    logic                          finf_reg;
    logic signed [SLOPE_WIDTH-1:0] older_slope_reg;
    logic signed [SLOPE_WIDTH-1:0] newer_slope_reg;
    logic                          older_inf_reg;
    logic                          newer_inf_reg;
    sign_t                         curv_reg;
    logic [1:0]                    seen_reg;
    logic [INDEX_WIDTH-1:0]        index_reg;
    logic                          m_valid_reg;
    ipd_out_t                      m_data_reg;

    logic                   dx_neg;
    logic                   dy_neg;
    logic                   dx_zero;
    logic [COORD_WIDTH:0]   adx_full;
    logic [COORD_WIDTH:0]   ady_full;
    logic [COORD_WIDTH:0]   trial;
    logic [COORD_WIDTH+1:0] diff;
    logic                   fits;
    logic [CMP_W-1:0]       q_ext;
    logic [CMP_W-1:0]       lim_ext;
    logic                   sat;
    logic [SLOPE_WIDTH-1:0] mag;
    logic [SLOPE_WIDTH-1:0] slope_val;
    sign_t                  curv_new;
    sign_t                  sign_old;
    sign_t                  sign_new;
    logic                   flip;
    logic                   detect;
    logic                   out_free;
    logic                   do_first;
    logic                   do_load;
    logic                   do_eval;

    assign dx_neg   = head.delta_x[COORD_WIDTH];
    assign dy_neg   = head.delta_y[COORD_WIDTH];
    assign dx_zero  = (head.delta_x == '0);
    assign adx_full = dx_neg ? (~head.delta_x + 1'b1) : head.delta_x;
    assign ady_full = dy_neg ? (~head.delta_y + 1'b1) : head.delta_y;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, adx_reg};
    assign fits  = !diff[COORD_WIDTH+1];

    assign q_ext   = CMP_W'(num_reg);
    assign lim_ext = neg_reg ? (CMP_W'(1) << (SLOPE_WIDTH - 1))
                             : ((CMP_W'(1) << (SLOPE_WIDTH - 1)) - CMP_W'(1));
    assign sat       = (q_ext > lim_ext);
    assign mag       = sat ? lim_ext[SLOPE_WIDTH-1:0] : q_ext[SLOPE_WIDTH-1:0];
    assign slope_val = neg_reg ? (~mag + 1'b1) : mag;

    always_comb begin
        if (finf_reg && newer_inf_reg) begin
            curv_new = SIGN_BAD;
        end else if (finf_reg) begin
            curv_new = SIGN_POS;
        end else if (newer_inf_reg) begin
            curv_new = SIGN_NEG;
        end else if (f_reg > newer_slope_reg) begin
            curv_new = SIGN_POS;
        end else if (f_reg < newer_slope_reg) begin
            curv_new = SIGN_NEG;
        end else begin
            curv_new = SIGN_ZERO;
        end

        if (older_inf_reg || (!older_slope_reg[SLOPE_WIDTH-1] && older_slope_reg != '0)) begin
            sign_old = SIGN_POS;
        end else if (older_slope_reg[SLOPE_WIDTH-1]) begin
            sign_old = SIGN_NEG;
        end else begin
            sign_old = SIGN_ZERO;
        end

        if (newer_inf_reg || (!newer_slope_reg[SLOPE_WIDTH-1] && newer_slope_reg != '0)) begin
            sign_new = SIGN_POS;
        end else if (newer_slope_reg[SLOPE_WIDTH-1]) begin
            sign_new = SIGN_NEG;
        end else begin
            sign_new = SIGN_ZERO;
        end
    end

    assign flip = ((curv_reg == SIGN_POS) && (curv_new == SIGN_NEG))
               || ((curv_reg == SIGN_NEG) && (curv_new == SIGN_POS));
    assign detect = (seen_reg == 2'd3) && flip && (sign_old != SIGN_ZERO)
                 && (sign_old == sign_new);

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;
    assign do_first = pop && head.first;
    assign do_load  = pop && !head.first;
    assign do_eval  = (state_reg == ST_EVAL) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (do_load) begin
                    state_next = dx_zero ? ST_EVAL : ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = ST_SLOPE;
                end
            end
            ST_SLOPE: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            seen_reg    <= 2'd0;
            curv_reg    <= SIGN_ZERO;
            index_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (do_eval && detect) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (do_first) begin
                seen_reg  <= 2'd1;
                curv_reg  <= SIGN_ZERO;
                index_reg <= '0;
            end else if (do_eval) begin
                if (seen_reg == 2'd1) begin
                    seen_reg <= 2'd2;
                end else begin
                    seen_reg <= 2'd3;
                    curv_reg <= curv_new;
                    if (index_reg != '1) begin
                        index_reg <= index_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_first) begin
            newer_x_reg <= head.point_x;
            newer_y_reg <= head.point_y;
        end
        if (do_load) begin
            cur_x_reg <= head.point_x;
            cur_y_reg <= head.point_y;
            neg_reg   <= dx_neg ^ dy_neg;
            adx_reg   <= adx_full[COORD_WIDTH-1:0];
            rem_reg   <= '0;
            num_reg   <= NUM_W'(ady_full[COORD_WIDTH-1:0]) << FRAC_BITS;
            step_reg  <= STEP_W'(NUM_W - 1);
            f_reg     <= '0;
            finf_reg  <= dx_zero;
        end
        if (state_reg == ST_DIV) begin
            rem_reg  <= fits ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
            num_reg  <= {num_reg[NUM_W-2:0], fits};
            step_reg <= step_reg - 1'b1;
        end
        if (state_reg == ST_SLOPE) begin
            f_reg <= slope_val;
        end
        if (do_eval) begin
            if (seen_reg != 2'd1) begin
                older_slope_reg <= newer_slope_reg;
                older_inf_reg   <= newer_inf_reg;
            end
            newer_slope_reg <= f_reg;
            newer_inf_reg   <= finf_reg;
            older_x_reg     <= newer_x_reg;
            older_y_reg     <= newer_y_reg;
            newer_x_reg     <= cur_x_reg;
            newer_y_reg     <= cur_y_reg;
            if (detect) begin
                m_data_reg.found_x     <= older_x_reg;
                m_data_reg.found_y     <= older_y_reg;
                m_data_reg.found_index <= index_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for inflection_point_detector_top
// A tracker class mirrors the detector's point history, slopes and
// curvature sign, and queues the inflection points it predicts for every
// accepted input transfer. Each output transfer is compared field by field
// with the oldest prediction. The stimulus covers directed corner points,
// random curve segments with turning curvature, noise, and a closing wave.
// ----------------------------------------------------------------------------
module testbench import ipd_pkg::*; ();

    localparam int FRAC_W  = 16;
    localparam int SLOPE_W = 48;
    localparam int ONE     = 1 << FRAC_W;
    localparam int MAXC    = 32'h7fff_ffff;
    localparam int MINC    = 32'h8000_0000;

    class inflection_tracker;
        logic signed [COORD_WIDTH-1:0] older_x, older_y, newer_x, newer_y;
        logic signed [SLOPE_W-1:0]     older_slope, newer_slope;
        bit                            older_inf, newer_inf;
        sign_t                         last_sign;
        int unsigned                   points_seen;
        logic [INDEX_WIDTH-1:0]        point_index;
        ipd_out_t                      found_due[$];
        int                            mismatches;

        function new();
            clear_history();
            mismatches = 0;
        endfunction

        function void clear_history();
            older_x = '0;
            older_y = '0;
            newer_x = '0;
            newer_y = '0;
            older_slope = '0;
            newer_slope = '0;
            older_inf = 1'b0;
            newer_inf = 1'b0;
            last_sign = SIGN_ZERO;
            points_seen = 0;
            point_index = '0;
        endfunction

        function void slope_of(input logic signed [COORD_WIDTH-1:0] x0, y0, x1, y1,
                               output logic signed [SLOPE_W-1:0] val, output bit inf);
            logic signed [COORD_WIDTH:0] dx, dy;
            logic [COORD_WIDTH:0]        adx, ady;
            logic [63:0]                 quo, lim;
            bit                          neg;
            dx = x1 - x0;
            dy = y1 - y0;
            val = '0;
            inf = (dx == 0);
            if (inf) begin
                return;
            end
            neg = dx[COORD_WIDTH] != dy[COORD_WIDTH];
            adx = dx[COORD_WIDTH] ? -dx : dx;
            ady = dy[COORD_WIDTH] ? -dy : dy;
            quo = (64'(ady) << FRAC_W) / 64'(adx);
            lim = (64'd1 << (SLOPE_W - 1)) - (neg ? 64'd0 : 64'd1);
            if (quo > lim) begin
                quo = lim;
            end
            val = neg ? SLOPE_W'(-quo) : SLOPE_W'(quo);
        endfunction

        function sign_t sign_of(logic signed [SLOPE_W-1:0] val, bit inf);
            if (inf || val > 0) begin
                return SIGN_POS;
            end
            return (val < 0) ? SIGN_NEG : SIGN_ZERO;
        endfunction

        function sign_t bend_of(logic signed [SLOPE_W-1:0] nv, bit ninf,
                                logic signed [SLOPE_W-1:0] ov, bit oinf);
            if (ninf && oinf) begin
                return SIGN_BAD;
            end
            if (ninf) begin
                return SIGN_POS;
            end
            if (oinf) begin
                return SIGN_NEG;
            end
            if (nv > ov) begin
                return SIGN_POS;
            end
            return (nv < ov) ? SIGN_NEG : SIGN_ZERO;
        endfunction

        function void note_point(ipd_in_t pt);
            logic signed [SLOPE_W-1:0] slope;
            bit                        inf;
            sign_t                     bend, so, sn;
            bit                        flip;
            ipd_out_t                  hit;
            if (pt.series_start) begin
                clear_history();
            end
            if (points_seen == 0) begin
                newer_x = pt.point_x;
                newer_y = pt.point_y;
                points_seen = 1;
                return;
            end
            slope_of(newer_x, newer_y, pt.point_x, pt.point_y, slope, inf);
            if (points_seen == 1) begin
                newer_slope = slope;
                newer_inf = inf;
                points_seen = 2;
            end else begin
                bend = bend_of(slope, inf, newer_slope, newer_inf);
                if (points_seen >= 3) begin
                    so = sign_of(older_slope, older_inf);
                    sn = sign_of(newer_slope, newer_inf);
                    flip = (last_sign == SIGN_POS && bend == SIGN_NEG) ||
                           (last_sign == SIGN_NEG && bend == SIGN_POS);
                    if (flip && so != SIGN_ZERO && so == sn) begin
                        hit.found_x = older_x;
                        hit.found_y = older_y;
                        hit.found_index = point_index;
                        found_due = {found_due, hit};
                    end
                end
                last_sign = bend;
                older_slope = newer_slope;
                older_inf = newer_inf;
                newer_slope = slope;
                newer_inf = inf;
                points_seen = 3;
                if (point_index != '1) begin
                    point_index++;
                end
            end
            older_x = newer_x;
            older_y = newer_y;
            newer_x = pt.point_x;
            newer_y = pt.point_y;
        endfunction

        function void check_found(ipd_out_t got);
            ipd_out_t want;
            if (found_due.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d index=%0d", $time,
                         got.found_x, got.found_y, got.found_index);
                mismatches++;
                return;
            end
            want = found_due.pop_front();
            if (got.found_x !== want.found_x) begin
                $display("%0t: found_x expected %0d, actual %0d", $time,
                         want.found_x, got.found_x);
                mismatches++;
            end
            if (got.found_y !== want.found_y) begin
                $display("%0t: found_y expected %0d, actual %0d", $time,
                         want.found_y, got.found_y);
                mismatches++;
            end
            if (got.found_index !== want.found_index) begin
                $display("%0t: found_index expected %0d, actual %0d", $time,
                         want.found_index, got.found_index);
                mismatches++;
            end
        endfunction

        function int pending();
            return found_due.size();
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ipd_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ipd_out_t m_data;

    inflection_tracker tracker = new();
    bit                no_idle = 1'b0;

    inflection_point_detector_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic ipd_in_t pt(int x, int y, bit start);
        ipd_in_t p;
        p.point_x = x;
        p.point_y = y;
        p.series_start = start;
        return p;
    endfunction

    task automatic send_point(ipd_in_t p);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        forever begin
            @(posedge aclk);
            if (s_ready) begin
                break;
            end
        end
        tracker.note_point(p);
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                tracker.check_found(m_data);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall = idle_len();
                end
            end
        end
    end

    initial begin
        int                            mode, len, turn, sent;
        bit                            breaks, start;
        logic signed [COORD_WIDTH-1:0] x, y, step, dy, ddy;
        int                            corners [7];
        corners = '{MINC, MAXC, 0, 1, -1, ONE, -ONE};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_point(pt(0, 0, 1'b0));
        send_point(pt(ONE, ONE, 1'b0));
        send_point(pt(ONE, 5 * ONE, 1'b0));
        send_point(pt(ONE, -3 * ONE, 1'b0));
        send_point(pt(2 * ONE, 0, 1'b0));
        send_point(pt(3 * ONE, 0, 1'b0));
        send_point(pt(0, 0, 1'b1));
        send_point(pt(ONE, ONE, 1'b0));
        send_point(pt(2 * ONE, 4 * ONE, 1'b0));
        send_point(pt(MINC, MINC, 1'b1));
        send_point(pt(MAXC, MAXC, 1'b0));
        send_point(pt(MINC, MAXC, 1'b0));
        send_point(pt(MINC + 1, MINC, 1'b0));
        send_point(pt(MINC + 2, MAXC, 1'b0));
        send_point(pt(MAXC, 0, 1'b0));
        send_point(pt(0, 0, 1'b1));
        send_point(pt(ONE, ONE, 1'b0));
        send_point(pt(2 * ONE, 3 * ONE, 1'b0));
        send_point(pt(3 * ONE, 6 * ONE, 1'b0));
        send_point(pt(4 * ONE, 8 * ONE, 1'b0));
        send_point(pt(5 * ONE, 9 * ONE, 1'b0));
        send_point(pt(0, 0, 1'b1));
        send_point(pt(ONE, -ONE, 1'b0));
        send_point(pt(2 * ONE, -3 * ONE, 1'b0));
        send_point(pt(3 * ONE, -6 * ONE, 1'b0));
        send_point(pt(4 * ONE, -8 * ONE, 1'b0));
        send_point(pt(5 * ONE, -9 * ONE, 1'b0));

        sent = 0;
        while (sent < 1180) begin
            mode = $urandom_range(0, 9);
            no_idle = ($urandom_range(0, 4) == 0);
            if (mode <= 5 || mode == 9) begin
                breaks = (mode == 9);
                len = $urandom_range(4, 24);
                turn = $urandom_range(1, len - 2);
                x = $urandom();
                step = $urandom_range(1, 1 << $urandom_range(0, 20));
                if ($urandom_range(0, 3) == 0) begin
                    step = -step;
                end
                y = $urandom();
                dy = $urandom_range(0, 1 << $urandom_range(4, 22));
                if ($urandom_range(0, 1) == 0) begin
                    dy = -dy;
                end
                ddy = $urandom_range(1, 1 << $urandom_range(0, 16));
                if ($urandom_range(0, 1) == 0) begin
                    ddy = -ddy;
                end
                for (int i = 0; i < len; i++) begin
                    start = (i == 0) || (breaks && $urandom_range(0, 7) == 0);
                    send_point(pt(x, y, start));
                    x += ($urandom_range(0, 15) == 0) ? 0 : step;
                    y += dy;
                    if (i == turn) begin
                        ddy = -ddy;
                    end
                    dy += ddy;
                end
                sent += len;
            end else if (mode <= 7) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    send_point(pt($urandom(), $urandom(), $urandom_range(0, 7) == 0));
                end
                sent += len;
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    send_point(pt(corners[$urandom_range(0, 6)], corners[$urandom_range(0, 6)],
                                  $urandom_range(0, 5) == 0));
                end
                sent += len;
            end
        end

        no_idle = 1'b0;
        x = $urandom();
        y = 0;
        dy = ONE;
        for (int i = 0; i < 40; i++) begin
            x += ONE;
            y += dy;
            dy += ((i % 6) < 3) ? ONE : -ONE;
            send_point(pt(x, y, 1'b0));
        end
        s_valid <= 1'b0;

        while (tracker.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (400) @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(30_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
